// ===== design/mpbm_pkg.sv =====
// Shared types and constants of the multi-pattern byte matcher.
package mpbm_pkg;

    // Field and register widths.
    localparam int BYTE_W     = 8;
    localparam int PAT_BYTES  = 8;
    localparam int PAT_DATA_W = PAT_BYTES * BYTE_W;
    localparam int PAT_LEN_W  = 4;
    localparam int NUM_SLOTS  = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_A_BYTES  = 4'd0,
        REG_PAT_A_LENGTH = 4'd1,
        REG_PAT_B_BYTES  = 4'd2,
        REG_PAT_B_LENGTH = 4'd3,
        REG_PAT_C_BYTES  = 4'd4,
        REG_PAT_C_LENGTH = 4'd5,
        REG_PAT_D_BYTES  = 4'd6,
        REG_PAT_D_LENGTH = 4'd7
    } t_reg_idx;

    // One configured pattern.
    typedef struct packed {
        logic [PAT_DATA_W-1:0] bytes;
        logic [PAT_LEN_W-1:0]  len;
    } t_pattern;

endpackage

// ===== design/mpbm_in_if.sv =====
// Input channel: one payload byte per transaction.
interface mpbm_in_if;
    logic                        valid;
    logic                        ready;
    logic [mpbm_pkg::BYTE_W-1:0] payload_byte;
    logic                        end_of_packet;

    modport source (output valid, payload_byte, end_of_packet, input ready);
    modport sink   (input valid, payload_byte, end_of_packet, output ready);
endinterface

// ===== design/mpbm_out_if.sv =====
// Result channel: one match flag per finished packet.
interface mpbm_out_if;
    logic valid;
    logic ready;
    logic pattern_found;

    modport source (output valid, pattern_found, input ready);
    modport sink   (input valid, pattern_found, output ready);
endinterface

// ===== design/mpbm_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface mpbm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mpbm_pkg::CFG_IDX_W-1:0]  index;
    logic [mpbm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/mpbm_cfg_regs.sv =====
// Pattern configuration register file.
module mpbm_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mpbm_cfg_if.sink             i_cfg_ch,
    output mpbm_pkg::t_pattern   o_pat [mpbm_pkg::NUM_SLOTS]
);

    mpbm_pkg::t_pattern r_pat [mpbm_pkg::NUM_SLOTS];
    logic               wr_en;

    // Writes are always taken.
    assign i_cfg_ch.ready = 1'b1;
    assign wr_en          = i_cfg_ch.valid;

    // Decode the register index; unused indexes change nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < mpbm_pkg::NUM_SLOTS; s++) begin
                r_pat[s] <= '0;
            end
        end else if (wr_en) begin
            unique case (mpbm_pkg::t_reg_idx'(i_cfg_ch.index))
                mpbm_pkg::REG_PAT_A_BYTES:  r_pat[0].bytes <= i_cfg_ch.data;
                mpbm_pkg::REG_PAT_A_LENGTH:
                    r_pat[0].len <= i_cfg_ch.data[mpbm_pkg::PAT_LEN_W-1:0];
                mpbm_pkg::REG_PAT_B_BYTES:  r_pat[1].bytes <= i_cfg_ch.data;
                mpbm_pkg::REG_PAT_B_LENGTH:
                    r_pat[1].len <= i_cfg_ch.data[mpbm_pkg::PAT_LEN_W-1:0];
                mpbm_pkg::REG_PAT_C_BYTES:  r_pat[2].bytes <= i_cfg_ch.data;
                mpbm_pkg::REG_PAT_C_LENGTH:
                    r_pat[2].len <= i_cfg_ch.data[mpbm_pkg::PAT_LEN_W-1:0];
                mpbm_pkg::REG_PAT_D_BYTES:  r_pat[3].bytes <= i_cfg_ch.data;
                mpbm_pkg::REG_PAT_D_LENGTH:
                    r_pat[3].len <= i_cfg_ch.data[mpbm_pkg::PAT_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_pat = r_pat;

endmodule

// ===== design/mpbm_pat_match.sv =====
// Compares one pattern against the window that ends at the current byte.
module mpbm_pat_match #(
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int CNT_W             = 3
) (
    input  mpbm_pkg::t_pattern          i_pat,
    input  logic [mpbm_pkg::BYTE_W-1:0] i_win [MAX_PATTERN_BYTES],
    input  logic [CNT_W-1:0]            i_count,
    output logic                        o_hit
);

    logic [MAX_PATTERN_BYTES-1:0] len_hit;
    logic                         len_ok;
    logic [mpbm_pkg::PAT_LEN_W-1:0] len_m1;

    // For every possible length, check the window at fixed positions.
    // Character k of a pattern of length l+1 lines up with window slot l-k,
    // where slot zero is the current byte.
    always_comb begin
        for (int l = 0; l < MAX_PATTERN_BYTES; l++) begin
            len_hit[l] = (i_count >= CNT_W'(l));
            for (int k = 0; k <= l; k++) begin
                if (i_pat.bytes[mpbm_pkg::BYTE_W*k +: mpbm_pkg::BYTE_W] != i_win[l-k]) begin
                    len_hit[l] = 1'b0;
                end
            end
        end
    end

    // A length of zero or beyond the window disables the pattern.
    assign len_ok = (i_pat.len != '0) &&
                    (i_pat.len <= mpbm_pkg::PAT_LEN_W'(MAX_PATTERN_BYTES));
    assign len_m1 = i_pat.len - 1'b1;
    assign o_hit  = len_ok && len_hit[len_m1[CNT_W-1:0]];

endmodule

// ===== design/multi_pattern_byte_matcher_unit.sv =====
// Result path: the last byte passes the input register, then loads the result register.
// Throughput: one payload byte per cycle, unless a waiting result holds a last byte;
// all pattern compares are combinational between the input and history/result registers.
// A result waiting on the output holds the next last-of-packet byte, and the input behind it.
// Reset (synchronous, active low) clears the patterns, history, count and hit flag.
module multi_pattern_byte_matcher_unit #(
    parameter int NUM_PATTERNS      = 4,
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpbm_cfg_if.sink    i_cfg_ch,
    mpbm_in_if.sink     i_in_ch,
    mpbm_out_if.source  o_out_ch
);

    localparam int HIST_W = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
    localparam int CNT_W  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PATTERN_BYTES - 1);

    mpbm_pkg::t_pattern          pat [mpbm_pkg::NUM_SLOTS];

    // Input register.
    logic                        r_s1_valid;
    logic [mpbm_pkg::BYTE_W-1:0] r_s1_byte;
    logic                        r_s1_eop;
    logic                        s1_adv;

    // Packet state.
    logic [mpbm_pkg::BYTE_W-1:0] r_hist [HIST_W];
    logic [mpbm_pkg::BYTE_W-1:0] n_hist [HIST_W];
    logic [CNT_W-1:0]            r_count;
    logic                        r_hit;

    // Result register.
    logic                        r_out_valid;
    logic                        r_out_found;

    logic [mpbm_pkg::BYTE_W-1:0] win [MAX_PATTERN_BYTES];
    logic [NUM_PATTERNS-1:0]     hit_vec;
    logic                        any_hit;

    mpbm_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_ch (i_cfg_ch),
        .o_pat    (pat)
    );

    // The registered byte advances unless it ends a packet while the
    // previous result still waits.
    assign s1_adv = r_s1_valid && !(r_s1_eop && r_out_valid && !o_out_ch.ready);
    assign i_in_ch.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_s1_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_s1_byte <= i_in_ch.payload_byte;
            r_s1_eop  <= i_in_ch.end_of_packet;
        end
    end

    // Window: the current byte followed by the bytes before it.
    assign win[0] = r_s1_byte;
    generate
        for (genvar w = 1; w < MAX_PATTERN_BYTES; w++) begin : g_win
            assign win[w] = r_hist[w-1];
        end
    endgenerate

    // One comparator per pattern slot.
    generate
        for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_match
            mpbm_pat_match #(
                .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
                .CNT_W             (CNT_W)
            ) u_match (
                .i_pat   (pat[p]),
                .i_win   (win),
                .i_count (r_count),
                .o_hit   (hit_vec[p])
            );
        end
    endgenerate

    assign any_hit = r_hit || (|hit_vec);

    // History shifts by one byte, newest first.
    always_comb begin
        n_hist[0] = r_s1_byte;
        for (int h = 1; h < HIST_W; h++) begin
            n_hist[h] = r_hist[h-1];
        end
    end

    // Packet state update; a last byte clears everything for the next packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hit   <= 1'b0;
            for (int h = 0; h < HIST_W; h++) begin
                r_hist[h] <= '0;
            end
        end else if (s1_adv) begin
            if (r_s1_eop) begin
                r_count <= '0;
                r_hit   <= 1'b0;
                for (int h = 0; h < HIST_W; h++) begin
                    r_hist[h] <= '0;
                end
            end else begin
                r_hit <= any_hit;
                if (r_count != CNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
                r_hist <= n_hist;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_eop) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_eop) begin
            r_out_found <= any_hit;
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.pattern_found = r_out_found;

`ifndef NO_ASSERTIONS
    // The byte count never passes the history depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("byte count beyond history depth");

    // A finished packet leaves a zero count and no hit flag behind.
    a_eop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_eop) |=> (r_count == '0) && !r_hit)
        else $error("packet state not cleared after last byte");

    // A new result only follows a last-of-packet transaction.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_adv && r_s1_eop))
        else $error("result produced without a last byte");

    // A waiting result is never overwritten by the next packet.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out_ch.ready) |-> !(s1_adv && r_s1_eop))
        else $error("pending result overwritten");
`endif

endmodule

// ===== test/multi_pattern_byte_matcher_unit_test.sv =====
// Self-checking testbench for the multi-pattern byte matcher: directed packets, then random packets.
`timescale 1ns / 1ps

module multi_pattern_byte_matcher_unit_test;

    localparam int HIST_DEPTH       = mpbm_pkg::PAT_BYTES - 1;
    localparam int PHASE_ITEMS      = 200;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 300;

    // Indexes outside the register map; writes to them must be ignored.
    localparam logic [mpbm_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 4'd8;
    localparam logic [mpbm_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = 4'd15;

    localparam mpbm_pkg::t_reg_idx BYTES_REG [mpbm_pkg::NUM_SLOTS] =
        '{mpbm_pkg::REG_PAT_A_BYTES, mpbm_pkg::REG_PAT_B_BYTES,
          mpbm_pkg::REG_PAT_C_BYTES, mpbm_pkg::REG_PAT_D_BYTES};
    localparam mpbm_pkg::t_reg_idx LENGTH_REG [mpbm_pkg::NUM_SLOTS] =
        '{mpbm_pkg::REG_PAT_A_LENGTH, mpbm_pkg::REG_PAT_B_LENGTH,
          mpbm_pkg::REG_PAT_C_LENGTH, mpbm_pkg::REG_PAT_D_LENGTH};

    typedef enum int {LEN_ALL_MAX, LEN_ALL_ONE, LEN_MIXED} t_len_mode;

    typedef struct packed {
        logic [mpbm_pkg::BYTE_W-1:0] payload_byte;
        logic                        end_of_packet;
    } t_byte_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mpbm_cfg_if cfg_ch ();
    mpbm_in_if  in_ch ();
    mpbm_out_if out_ch ();

    multi_pattern_byte_matcher_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_ch (cfg_ch),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // Stimulus and expectation stores.
    t_byte_item byte_queue [$];
    bit         found_queue [$];
    int         queued_items = 0;
    int         error_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       hold_active = 1'b0;
    event       long_hold_go;
    t_byte_item next_item;
    bit         expected_found;

    // Pattern plan of the current phase, used only to shape stimulus.
    logic [mpbm_pkg::PAT_DATA_W-1:0] plan_bytes [mpbm_pkg::NUM_SLOTS];
    int                              plan_len [mpbm_pkg::NUM_SLOTS];

    // Matcher state and registers as the predictor sees them.
    logic [mpbm_pkg::PAT_DATA_W-1:0] pat_bytes_cfg [mpbm_pkg::NUM_SLOTS] = '{default: '0};
    logic [mpbm_pkg::PAT_LEN_W-1:0]  pat_len_cfg [mpbm_pkg::NUM_SLOTS] = '{default: '0};
    logic [mpbm_pkg::BYTE_W-1:0]     history [HIST_DEPTH] = '{default: '0};
    int                              hist_count = 0;
    bit                              packet_hit = 1'b0;

    // True when the pattern in the slot ends exactly at the current byte.
    function automatic bit window_hit(int slot, logic [mpbm_pkg::BYTE_W-1:0] cur);
        int n;
        int j;
        logic [mpbm_pkg::BYTE_W-1:0] want;
        logic [mpbm_pkg::BYTE_W-1:0] got;
        n = pat_len_cfg[slot];
        if (n == 0 || n > mpbm_pkg::PAT_BYTES) return 1'b0;
        if (hist_count < n - 1) return 1'b0;
        for (j = 0; j < n; j++) begin
            want = pat_bytes_cfg[slot][mpbm_pkg::BYTE_W*(n-1-j) +: mpbm_pkg::BYTE_W];
            got  = (j == 0) ? cur : history[j-1];
            if (want !== got) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the matcher by one payload byte; a last byte yields a flag.
    task automatic predict_byte(input logic [mpbm_pkg::BYTE_W-1:0] cur, input logic last);
        bit hit;
        int s;
        int j;
        hit = packet_hit;
        for (s = 0; s < mpbm_pkg::NUM_SLOTS; s++)
            if (window_hit(s, cur)) hit = 1'b1;
        if (last) begin
            found_queue.insert(found_queue.size(), hit);
            history    = '{default: '0};
            hist_count = 0;
            packet_hit = 1'b0;
        end else begin
            packet_hit = hit;
            for (j = HIST_DEPTH - 1; j > 0; j--) history[j] = history[j-1];
            history[0] = cur;
            if (hist_count < HIST_DEPTH) hist_count++;
        end
    endtask

    // Mirror one register write into the predictor.
    task automatic apply_reg_write(input logic [mpbm_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [mpbm_pkg::CFG_DATA_W-1:0] value);
        unique case (idx)
            mpbm_pkg::REG_PAT_A_BYTES, mpbm_pkg::REG_PAT_B_BYTES,
            mpbm_pkg::REG_PAT_C_BYTES, mpbm_pkg::REG_PAT_D_BYTES: begin
                pat_bytes_cfg[idx >> 1] = value;
            end
            mpbm_pkg::REG_PAT_A_LENGTH, mpbm_pkg::REG_PAT_B_LENGTH,
            mpbm_pkg::REG_PAT_C_LENGTH, mpbm_pkg::REG_PAT_D_LENGTH: begin
                pat_len_cfg[idx >> 1] = value[mpbm_pkg::PAT_LEN_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // Payload driver: pops the pending queue, idles at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (byte_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_item = byte_queue.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.payload_byte  <= next_item.payload_byte;
                in_ch.end_of_packet <= next_item.end_of_packet;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus the occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_active) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long hold-off, counted here so the sender keeps offering bytes meanwhile.
    initial begin
        forever begin
            @(long_hold_go);
            @(posedge i_clk);
            hold_active <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    // Monitor: mirror register writes, predict each byte, check each result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) apply_reg_write(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                predict_byte(in_ch.payload_byte, in_ch.end_of_packet);
            if (out_ch.valid && out_ch.ready) begin
                if (found_queue.size() == 0) begin
                    $display("%0t: result with none expected, actual pattern_found=%0b",
                             $time, out_ch.pattern_found);
                    error_count++;
                end else begin
                    expected_found = found_queue.pop_front();
                    if (out_ch.pattern_found !== expected_found) begin
                        $display("%0t: pattern_found expected %0b actual %0b",
                                 $time, expected_found, out_ch.pattern_found);
                        error_count++;
                    end
                end
            end
        end
    end

    function automatic logic [mpbm_pkg::CFG_DATA_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Bytes lean toward a small alphabet so short patterns also match by chance.
    function automatic logic [mpbm_pkg::BYTE_W-1:0] random_char();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 8) return mpbm_pkg::BYTE_W'(8'h61 + $urandom_range(0, 3));
        if (pick == 8) return 8'h00;
        if (pick == 9) return 8'hFF;
        return mpbm_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    // One register write transaction; call at a rising edge, leaves valid high.
    task automatic write_reg(input logic [mpbm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mpbm_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic push_byte(input logic [mpbm_pkg::BYTE_W-1:0] b, input logic last);
        t_byte_item item;
        item.payload_byte  = b;
        item.end_of_packet = last;
        byte_queue.insert(byte_queue.size(), item);
        queued_items++;
    endtask

    // Packet of n bytes (at most eight), first byte in the low bits.
    task automatic push_packet(input logic [mpbm_pkg::PAT_DATA_W-1:0] bytes, input int n);
        int k;
        for (k = 0; k < n; k++)
            push_byte(bytes[mpbm_pkg::BYTE_W*k +: mpbm_pkg::BYTE_W], k == n - 1);
    endtask

    // Random packet, often carrying a copy or a near miss of a planned pattern.
    task automatic push_random_packet();
        logic [mpbm_pkg::BYTE_W-1:0] pkt [$];
        int n;
        int slot;
        int m;
        int pos;
        int k;
        int flip;
        n = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 24 : 10);
        for (k = 0; k < n; k++) pkt.insert(pkt.size(), random_char());
        if ($urandom_range(0, 9) < 6) begin
            slot = $urandom_range(0, mpbm_pkg::NUM_SLOTS - 1);
            m = (plan_len[slot] >= 1 && plan_len[slot] <= mpbm_pkg::PAT_BYTES) ?
                plan_len[slot] : $urandom_range(1, mpbm_pkg::PAT_BYTES);
            while (pkt.size() < m) pkt.insert(pkt.size(), random_char());
            pos = $urandom_range(0, pkt.size() - m);
            for (k = 0; k < m; k++)
                pkt[pos+k] = plan_bytes[slot][mpbm_pkg::BYTE_W*k +: mpbm_pkg::BYTE_W];
            if ($urandom_range(0, 3) == 0) begin
                flip = pos + $urandom_range(0, m - 1);
                pkt[flip] = pkt[flip] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        for (k = 0; k < pkt.size(); k++) push_byte(pkt[k], k == pkt.size() - 1);
    endtask

    task automatic plan_config(input t_len_mode mode);
        int s;
        int k;
        int r;
        for (s = 0; s < mpbm_pkg::NUM_SLOTS; s++) begin
            for (k = 0; k < mpbm_pkg::PAT_BYTES; k++)
                plan_bytes[s][mpbm_pkg::BYTE_W*k +: mpbm_pkg::BYTE_W] = random_char();
            unique case (mode)
                LEN_ALL_MAX: plan_len[s] = mpbm_pkg::PAT_BYTES;
                LEN_ALL_ONE: plan_len[s] = 1;
                default: begin
                    r = $urandom_range(0, 19);
                    if (r < 2) plan_len[s] = 0;
                    else if (r < 4) plan_len[s] = $urandom_range(mpbm_pkg::PAT_BYTES + 1, 15);
                    else plan_len[s] = $urandom_range(1, mpbm_pkg::PAT_BYTES);
                end
            endcase
        end
    endtask

    // Write an unused index, then the planned patterns; length writes carry junk in the upper bits.
    task automatic program_config();
        logic [mpbm_pkg::CFG_DATA_W-1:0] junk;
        int s;
        write_reg(mpbm_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                  random_word());
        for (s = 0; s < mpbm_pkg::NUM_SLOTS; s++) begin
            junk = random_word();
            write_reg(BYTES_REG[s], plan_bytes[s]);
            write_reg(LENGTH_REG[s], {junk[mpbm_pkg::CFG_DATA_W-1:mpbm_pkg::PAT_LEN_W],
                                      mpbm_pkg::PAT_LEN_W'(plan_len[s])});
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every byte went in and every result came out, then settle.
    task automatic wait_drained();
        while (byte_queue.size() != 0 || in_ch.valid || found_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input t_len_mode mode, input int send_pct,
                                    input int recv_pct, input bit long_hold);
        int start;
        plan_config(mode);
        program_config();
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (long_hold) -> long_hold_go;
        start = queued_items;
        while (queued_items - start < PHASE_ITEMS) push_random_packet();
        wait_drained();
    endtask

    // Main sequence.
    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.payload_byte  = '0;
        in_ch.end_of_packet = 1'b0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All patterns disabled after reset: a zero byte must not match.
        @(negedge i_clk);
        push_packet(64'h00, 1);
        wait_drained();

        // Directed patterns: two bytes with junk above, one 0xFF byte,
        // a full eight bytes, and an over-long length that disables it.
        write_reg(mpbm_pkg::REG_PAT_A_BYTES, 64'hA5A5_5A5A_0000_4241);
        write_reg(mpbm_pkg::REG_PAT_A_LENGTH, 64'd2);
        write_reg(mpbm_pkg::REG_PAT_B_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(mpbm_pkg::REG_PAT_B_LENGTH, 64'd1);
        write_reg(mpbm_pkg::REG_PAT_C_BYTES, 64'h0807_0605_0403_0201);
        write_reg(mpbm_pkg::REG_PAT_C_LENGTH, 64'd8);
        write_reg(mpbm_pkg::REG_PAT_D_BYTES, 64'h0);
        write_reg(mpbm_pkg::REG_PAT_D_LENGTH, 64'd15);
        write_reg(REG_UNUSED_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        push_packet(64'h00_4241, 3);            // hit mid-packet stays sticky
        push_packet(64'h41, 1);                 // pattern split over two packets
        push_packet(64'h42, 1);
        push_packet(64'hFF, 1);                 // single-byte pattern, top byte value
        push_packet(64'h0807_0605_0403_0201, 8);
        push_packet(64'h00_0000, 3);            // over-long pattern never matches
        push_packet(64'h07_0605_0403_0201, 7);  // too few bytes for the long one
        wait_drained();

        // Random phases over several settings and idling mixes.
        run_random_phase(LEN_ALL_MAX, 0, 0, 1'b1);
        run_random_phase(LEN_ALL_ONE, 87, 0, 1'b0);
        run_random_phase(LEN_MIXED, 0, 87, 1'b0);
        run_random_phase(LEN_MIXED, 29, 29, 1'b0);
        run_random_phase(LEN_MIXED, 0, 0, 1'b0);

        if (found_queue.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, found_queue.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mpbm_pkg.sv
design/mpbm_in_if.sv
design/mpbm_out_if.sv
design/mpbm_cfg_if.sv
design/mpbm_cfg_regs.sv
design/mpbm_pat_match.sv
design/multi_pattern_byte_matcher_unit.sv
test/multi_pattern_byte_matcher_unit_test.sv
